FILE: rtl/mwem_pkg.sv
package mwem_pkg;

    // command codes as they arrive on the input beat
    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_READ  = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_WEN   = 3'd3,
        CMD_WDS   = 3'd4
    } t_cmd;

    // sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START   = 4'd1,
        PH_OPCODE  = 4'd2,
        PH_ADDRESS = 4'd3,
        PH_RDATA   = 4'd4,
        PH_CLOSE   = 4'd5,
        PH_WDATA   = 4'd6,
        PH_WAIT    = 4'd7,
        PH_END     = 4'd8
    } t_phase;

    // microwire opcodes, sent msb first after the start bit
    localparam logic [1:0] OPC_READ  = 2'b10;
    localparam logic [1:0] OPC_WRITE = 2'b01;
    localparam logic [1:0] OPC_EWX   = 2'b00;

    // width of the read word port
    localparam int unsigned WORD_W = 16;

endpackage

FILE: rtl/mwem_front.sv
module mwem_front #(
    parameter int unsigned ADDR_BITS = 8,
    parameter int unsigned DATA_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [2:0]            i_cmd,
    input  logic [7:0]            i_word_address,
    input  logic [15:0]           i_write_word,
    input  logic                  i_serial_data_out,
    output logic                  o_valid,
    input  logic                  i_pop,
    output mwem_pkg::t_cmd        o_kind,
    output logic [ADDR_BITS-1:0]  o_addr,
    output logic [DATA_BITS-1:0]  o_data,
    output logic                  o_dout
);
    import mwem_pkg::*;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QW     = $clog2(QDEPTH);

    t_cmd                 c_kind;
    logic [ADDR_BITS-1:0] c_addr;
    logic [DATA_BITS-1:0] c_data;

    t_cmd                 r_kind_q [QDEPTH];
    logic [ADDR_BITS-1:0] r_addr_q [QDEPTH];
    logic [DATA_BITS-1:0] r_data_q [QDEPTH];
    logic                 r_dout_q [QDEPTH];

    logic [QW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QW:0]   r_count, n_count;
    logic          push;
    logic          pop;

    // classify the command and prepare the address and data patterns
    always_comb begin
        c_kind = CMD_TICK;
        c_addr = '0;
        c_data = '0;
        unique case (i_cmd)
            CMD_READ: begin
                c_kind = CMD_READ;
                c_addr = ADDR_BITS'(i_word_address);
            end
            CMD_WRITE: begin
                c_kind = CMD_WRITE;
                c_addr = ADDR_BITS'(i_word_address);
                c_data = DATA_BITS'(i_write_word);
            end
            CMD_WEN: begin
                c_kind = CMD_WEN;
                c_addr = '1;
            end
            CMD_WDS: begin
                c_kind = CMD_WDS;
            end
            default: begin
                c_kind = CMD_TICK;
            end
        endcase
    end

    // queue handshake
    assign o_stall = (r_count == (QW + 1)'(QDEPTH));
    assign push    = i_valid && !o_stall;
    assign o_valid = (r_count != '0);
    assign pop     = i_pop && o_valid;

    assign n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
    assign n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
    always_comb begin
        n_count = r_count;
        case ({push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_kind_q[r_wr_ptr] <= c_kind;
            r_addr_q[r_wr_ptr] <= c_addr;
            r_data_q[r_wr_ptr] <= c_data;
            r_dout_q[r_wr_ptr] <= i_serial_data_out;
        end
    end

    assign o_kind = r_kind_q[r_rd_ptr];
    assign o_addr = r_addr_q[r_rd_ptr];
    assign o_data = r_data_q[r_rd_ptr];
    assign o_dout = r_dout_q[r_rd_ptr];

    // occupancy matches pointer distance
    a_count_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != (QW + 1)'(QDEPTH)) |-> (QW'(r_count) == QW'(r_wr_ptr - r_rd_ptr)))
        else $error("queue count and pointers disagree");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QW + 1)'(QDEPTH))
        else $error("queue overflow");

endmodule

FILE: rtl/mwem_seq.sv
module mwem_seq #(
    parameter int unsigned ADDR_BITS = 8,
    parameter int unsigned DATA_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_pop,
    input  mwem_pkg::t_cmd        i_kind,
    input  logic [ADDR_BITS-1:0]  i_addr,
    input  logic [DATA_BITS-1:0]  i_data,
    input  logic                  i_dout,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_chip_select,
    output logic                  o_clock_pulse,
    output logic                  o_serial_data_in,
    output logic                  o_output_float,
    output logic                  o_busy_res,
    output logic [15:0]           o_read_word,
    output logic                  o_word_valid,
    output logic                  o_done_res,
    output logic                  o_rejected
);
    import mwem_pkg::*;

    localparam int unsigned MAXB  = (ADDR_BITS > DATA_BITS) ? ADDR_BITS : DATA_BITS;
    localparam int unsigned CNT_W = $clog2(MAXB);
    localparam logic [CNT_W-1:0] ADDR_LAST = CNT_W'(ADDR_BITS - 1);
    localparam logic [CNT_W-1:0] DATA_LAST = CNT_W'(DATA_BITS - 1);

    t_phase               r_phase, n_phase;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    t_cmd                 r_op, n_op;
    logic [ADDR_BITS-1:0] r_addr_sh, n_addr_sh;
    logic [DATA_BITS-1:0] r_data_sh, n_data_sh;
    logic [DATA_BITS-1:0] rd_shift;
    logic [1:0]           opcode;
    logic                 go;

    logic        c_cs, c_clk, c_di, c_flt, c_busy, c_wvalid, c_done, c_rej;
    logic [15:0] c_word;

    logic        r_out_valid;
    logic        r_cs, r_clk, r_di, r_flt, r_busy, r_wvalid, r_done, r_rej;
    logic [15:0] r_word;

    // one beat is consumed whenever the output register can take its result
    assign go    = i_valid && (!r_out_valid || !i_stall);
    assign o_pop = go;

    assign rd_shift = {r_data_sh[DATA_BITS-2:0], i_dout};

    always_comb begin
        unique case (r_op)
            CMD_READ:  opcode = OPC_READ;
            CMD_WRITE: opcode = OPC_WRITE;
            default:   opcode = OPC_EWX;
        endcase
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE:    n_phase = (i_kind != CMD_TICK) ? PH_START : PH_IDLE;
            PH_START:   n_phase = PH_OPCODE;
            PH_OPCODE:  n_phase = r_cnt[0] ? PH_ADDRESS : PH_OPCODE;
            PH_ADDRESS: begin
                if (r_cnt == ADDR_LAST) begin
                    if (r_op == CMD_READ) begin
                        n_phase = PH_RDATA;
                    end else if (r_op == CMD_WRITE) begin
                        n_phase = PH_WDATA;
                    end else begin
                        n_phase = PH_END;
                    end
                end
            end
            PH_RDATA:   n_phase = (r_cnt == DATA_LAST) ? PH_CLOSE : PH_RDATA;
            PH_CLOSE:   n_phase = PH_IDLE;
            PH_WDATA:   n_phase = (r_cnt == DATA_LAST) ? PH_WAIT : PH_WDATA;
            PH_WAIT:    n_phase = i_dout ? PH_IDLE : PH_WAIT;
            PH_END:     n_phase = PH_IDLE;
            default:    n_phase = PH_IDLE;
        endcase
    end

    // pin levels, flags and datapath for this slot
    always_comb begin
        c_cs      = 1'b0;
        c_clk     = 1'b0;
        c_di      = 1'b0;
        c_flt     = 1'b0;
        c_busy    = 1'b0;
        c_wvalid  = 1'b0;
        c_done    = 1'b0;
        c_word    = '0;
        c_rej     = (r_phase != PH_IDLE) && (i_kind != CMD_TICK);
        n_cnt     = r_cnt;
        n_op      = r_op;
        n_addr_sh = r_addr_sh;
        n_data_sh = r_data_sh;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_kind != CMD_TICK) begin
                    c_cs      = 1'b1;
                    c_clk     = 1'b1;
                    c_busy    = 1'b1;
                    n_op      = i_kind;
                    n_addr_sh = i_addr;
                    n_data_sh = i_data;
                    n_cnt     = '0;
                end
            end
            PH_START: begin
                c_cs   = 1'b1;
                c_clk  = 1'b1;
                c_di   = 1'b1;
                c_busy = 1'b1;
                n_cnt  = '0;
            end
            PH_OPCODE: begin
                c_cs   = 1'b1;
                c_clk  = 1'b1;
                c_busy = 1'b1;
                c_di   = r_cnt[0] ? opcode[0] : opcode[1];
                n_cnt  = r_cnt[0] ? '0 : r_cnt + 1'b1;
            end
            PH_ADDRESS: begin
                c_cs      = 1'b1;
                c_clk     = 1'b1;
                c_busy    = 1'b1;
                c_di      = r_addr_sh[ADDR_BITS-1];
                n_addr_sh = r_addr_sh << 1;
                if (r_cnt == ADDR_LAST) begin
                    n_cnt = '0;
                    if (r_op == CMD_READ) begin
                        n_data_sh = '0;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            PH_RDATA: begin
                c_cs      = 1'b1;
                c_clk     = 1'b1;
                c_flt     = 1'b1;
                c_busy    = 1'b1;
                n_data_sh = rd_shift;
                if (r_cnt == DATA_LAST) begin
                    c_wvalid = 1'b1;
                    c_word   = WORD_W'(rd_shift);
                    n_cnt    = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            PH_CLOSE: begin
                c_clk  = 1'b1;
                c_flt  = 1'b1;
                c_busy = 1'b1;
                c_done = 1'b1;
            end
            PH_WDATA: begin
                c_cs      = 1'b1;
                c_clk     = 1'b1;
                c_busy    = 1'b1;
                c_di      = r_data_sh[DATA_BITS-1];
                n_data_sh = r_data_sh << 1;
                n_cnt     = (r_cnt == DATA_LAST) ? '0 : r_cnt + 1'b1;
            end
            PH_WAIT: begin
                c_flt  = 1'b1;
                c_busy = 1'b1;
                c_done = i_dout;
            end
            PH_END: begin
                c_busy = 1'b1;
                c_done = 1'b1;
            end
            default: begin
                c_busy = 1'b0;
            end
        endcase
    end

    // sequencer state, advanced one slot per consumed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cnt     <= '0;
            r_op      <= CMD_TICK;
            r_addr_sh <= '0;
            r_data_sh <= '0;
        end else if (go) begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_op      <= n_op;
            r_addr_sh <= n_addr_sh;
            r_data_sh <= n_data_sh;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_cs     <= c_cs;
            r_clk    <= c_clk;
            r_di     <= c_di;
            r_flt    <= c_flt;
            r_busy   <= c_busy;
            r_word   <= c_word;
            r_wvalid <= c_wvalid;
            r_done   <= c_done;
            r_rej    <= c_rej;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_chip_select    = r_cs;
    assign o_clock_pulse    = r_clk;
    assign o_serial_data_in = r_di;
    assign o_output_float   = r_flt;
    assign o_busy_res       = r_busy;
    assign o_read_word      = r_word;
    assign o_word_valid     = r_wvalid;
    assign o_done_res       = r_done;
    assign o_rejected       = r_rej;

    // a completed read word always leaves the sequencer in the closing slot
    a_word_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_wvalid) |-> (r_phase == PH_CLOSE))
        else $error("read word shown outside the closing slot");

    // an idle beat leaves the sequencer idle
    a_idle_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_busy) |-> (r_phase == PH_IDLE))
        else $error("non-busy beat while sequence running");

    // a rejected command only happens inside a running sequence
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rej) |-> r_busy)
        else $error("rejected beat without busy");

    // opcode phase never runs past its two bits
    a_opc_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_OPCODE) |-> (r_cnt <= CNT_W'(1)))
        else $error("opcode bit count out of range");

endmodule

FILE: rtl/microwire_eeprom_master_top.sv
// channel | direction | handshake               | payload
// in      | input     | i_in_valid/o_in_stall   | i_cmd .. i_serial_data_out
// out     | output    | o_out_valid/i_out_stall | o_chip_select .. o_rejected
//
// each input beat is one serial bit slot and yields exactly one output beat
// one beat per clock sustained while the output is not stalled
// a beat crosses a 4-deep queue and then the output register
// the phase sequencer advances one slot for each beat it moves into the output register
// i_rst_n is synchronous: queue empties, sequencer returns to idle, output goes invalid
// an output stall holds the sequencer; the queue keeps taking beats until full
module microwire_eeprom_master_top #(
    parameter int unsigned ADDR_BITS = 8,
    parameter int unsigned DATA_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_word_address,
    input  logic [15:0] i_write_word,
    input  logic        i_serial_data_out,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_chip_select,
    output logic        o_clock_pulse,
    output logic        o_serial_data_in,
    output logic        o_output_float,
    output logic        o_busy_res,
    output logic [15:0] o_read_word,
    output logic        o_word_valid,
    output logic        o_done_res,
    output logic        o_rejected
);
    import mwem_pkg::*;

    logic                 q_valid;
    logic                 q_pop;
    t_cmd                 q_kind;
    logic [ADDR_BITS-1:0] q_addr;
    logic [DATA_BITS-1:0] q_data;
    logic                 q_dout;

    // front: classify and queue
    mwem_front #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_in_valid),
        .o_stall           (o_in_stall),
        .i_cmd             (i_cmd),
        .i_word_address    (i_word_address),
        .i_write_word      (i_write_word),
        .i_serial_data_out (i_serial_data_out),
        .o_valid           (q_valid),
        .i_pop             (q_pop),
        .o_kind            (q_kind),
        .o_addr            (q_addr),
        .o_data            (q_data),
        .o_dout            (q_dout)
    );

    // back: microwire sequencer and output register
    mwem_seq #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (q_valid),
        .o_pop            (q_pop),
        .i_kind           (q_kind),
        .i_addr           (q_addr),
        .i_data           (q_data),
        .i_dout           (q_dout),
        .o_valid          (o_out_valid),
        .i_stall          (i_out_stall),
        .o_chip_select    (o_chip_select),
        .o_clock_pulse    (o_clock_pulse),
        .o_serial_data_in (o_serial_data_in),
        .o_output_float   (o_output_float),
        .o_busy_res       (o_busy_res),
        .o_read_word      (o_read_word),
        .o_word_valid     (o_word_valid),
        .o_done_res       (o_done_res),
        .o_rejected       (o_rejected)
    );

endmodule

FILE: bench/mw_slot_checker.sv
module mw_slot_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_word_address,
    input  logic [15:0] i_write_word,
    input  logic        i_serial_data_out,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_chip_select,
    input  logic        i_clock_pulse,
    input  logic        i_serial_data_in,
    input  logic        i_output_float,
    input  logic        i_busy_res,
    input  logic [15:0] i_read_word,
    input  logic        i_word_valid,
    input  logic        i_done_res,
    input  logic        i_rejected,
    output int          o_fail_count,
    output int          o_pending
);
    import mwem_pkg::*;

    localparam int unsigned ADDR_W     = 8;
    localparam int unsigned DATA_W     = 16;
    localparam int unsigned REPORT_MAX = 10;

    // pin levels and flags of one serial bit slot
    typedef struct packed {
        logic              cs;
        logic              sk;
        logic              di;
        logic              flt;
        logic              busy;
        logic [DATA_W-1:0] word;
        logic              word_valid;
        logic              done;
        logic              rejected;
    } t_pins;

    // shadow of the sequencer
    t_phase            seq_phase;
    logic [4:0]        bit_idx;
    t_cmd              seq_op;
    logic [ADDR_W-1:0] addr_sr;
    logic [DATA_W-1:0] data_sr;

    t_pins pins_due[$];
    int    mismatches = 0;
    int    n_due = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = n_due;

    function automatic logic [1:0] opcode_of(input t_cmd op);
        case (op)
            CMD_READ:  return OPC_READ;
            CMD_WRITE: return OPC_WRITE;
            default:   return OPC_EWX;
        endcase
    endfunction

    function automatic string pins_text(input t_pins p);
        return $sformatf("cs=%b sk=%b di=%b float=%b busy=%b word=%h valid=%b done=%b rej=%b",
                         p.cs, p.sk, p.di, p.flt, p.busy, p.word, p.word_valid, p.done,
                         p.rejected);
    endfunction

    // advance the shadow sequencer by one slot and return its pins
    task automatic advance_slot(input logic [2:0] c, input logic [7:0] a,
                                input logic [15:0] w, input logic d, output t_pins p);
        logic       is_cmd;
        logic [1:0] code;
        is_cmd = (c >= CMD_READ) && (c <= CMD_WDS);
        p = '0;
        p.rejected = is_cmd && (seq_phase != PH_IDLE);
        case (seq_phase)
            PH_IDLE: begin
                if (is_cmd) begin
                    seq_op = t_cmd'(c);
                    case (seq_op)
                        CMD_WEN: addr_sr = '1;
                        CMD_WDS: addr_sr = '0;
                        default: addr_sr = a;
                    endcase
                    data_sr = (seq_op == CMD_WRITE) ? w : '0;
                    bit_idx = '0;
                    p.cs = 1'b1;
                    p.sk = 1'b1;
                    p.busy = 1'b1;
                    seq_phase = PH_START;
                end
            end
            PH_START: begin
                p.cs = 1'b1;
                p.sk = 1'b1;
                p.di = 1'b1;
                p.busy = 1'b1;
                bit_idx = '0;
                seq_phase = PH_OPCODE;
            end
            PH_OPCODE: begin
                p.cs = 1'b1;
                p.sk = 1'b1;
                p.busy = 1'b1;
                code = opcode_of(seq_op);
                p.di = bit_idx[0] ? code[0] : code[1];
                if (bit_idx >= 1) begin
                    bit_idx = '0;
                    seq_phase = PH_ADDRESS;
                end else begin
                    bit_idx++;
                end
            end
            PH_ADDRESS: begin
                p.cs = 1'b1;
                p.sk = 1'b1;
                p.busy = 1'b1;
                if (bit_idx >= ADDR_W - 1) bit_idx = 5'(ADDR_W - 1);
                p.di = addr_sr[ADDR_W - 1 - bit_idx];
                if (bit_idx == ADDR_W - 1) begin
                    bit_idx = '0;
                    case (seq_op)
                        CMD_READ: begin
                            data_sr = '0;
                            seq_phase = PH_RDATA;
                        end
                        CMD_WRITE: seq_phase = PH_WDATA;
                        default:   seq_phase = PH_END;
                    endcase
                end else begin
                    bit_idx++;
                end
            end
            PH_RDATA: begin
                p.cs = 1'b1;
                p.sk = 1'b1;
                p.flt = 1'b1;
                p.busy = 1'b1;
                data_sr = {data_sr[DATA_W-2:0], d};
                if (bit_idx >= DATA_W - 1) begin
                    p.word_valid = 1'b1;
                    p.word = data_sr;
                    bit_idx = '0;
                    seq_phase = PH_CLOSE;
                end else begin
                    bit_idx++;
                end
            end
            PH_CLOSE: begin
                p.sk = 1'b1;
                p.flt = 1'b1;
                p.busy = 1'b1;
                p.done = 1'b1;
                seq_phase = PH_IDLE;
            end
            PH_WDATA: begin
                p.cs = 1'b1;
                p.sk = 1'b1;
                p.busy = 1'b1;
                if (bit_idx >= DATA_W - 1) bit_idx = 5'(DATA_W - 1);
                p.di = data_sr[DATA_W - 1 - bit_idx];
                if (bit_idx == DATA_W - 1) begin
                    bit_idx = '0;
                    seq_phase = PH_WAIT;
                end else begin
                    bit_idx++;
                end
            end
            // write cycle runs until the eeprom pulls its data pin high
            PH_WAIT: begin
                p.flt = 1'b1;
                p.busy = 1'b1;
                if (d) begin
                    p.done = 1'b1;
                    seq_phase = PH_IDLE;
                end
            end
            PH_END: begin
                p.busy = 1'b1;
                p.done = 1'b1;
                seq_phase = PH_IDLE;
            end
            default: seq_phase = PH_IDLE;
        endcase
    endtask

    // predict on input beats, compare on output beats
    always @(posedge i_clk) begin
        t_pins want;
        t_pins got;
        if (!i_rst_n) begin
            seq_phase = PH_IDLE;
            bit_idx   = '0;
            seq_op    = CMD_TICK;
            addr_sr   = '0;
            data_sr   = '0;
            pins_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                advance_slot(i_cmd, i_word_address, i_write_word, i_serial_data_out, want);
                pins_due.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_chip_select, i_clock_pulse, i_serial_data_in, i_output_float,
                        i_busy_res, i_read_word, i_word_valid, i_done_res, i_rejected};
                if (pins_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: output beat with nothing predicted: %s",
                                 $time, pins_text(got));
                end else begin
                    want = pins_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display("%0t: slot mismatch", $time);
                            $display("  expected %s", pins_text(want));
                            $display("  actual   %s", pins_text(got));
                        end
                    end
                end
            end
        end
        n_due = pins_due.size();
    end

endmodule

FILE: bench/testbench.sv
module testbench;
    import mwem_pkg::*;

    localparam int unsigned RANDOM_SLOTS = 1600;
    localparam int unsigned DRAIN_EVERY  = 400;
    localparam int unsigned IDLE_LIMIT   = 2000;

    // idling styles
    localparam int IDLE_NONE  = 0;
    localparam int IDLE_FULL  = 1;
    localparam int IDLE_LIGHT = 2;

    // level of the eeprom data pin across a sequence body
    localparam int unsigned DOUT_LOW  = 0;
    localparam int unsigned DOUT_HIGH = 1;
    localparam int unsigned DOUT_RAND = 2;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  cmd;
    logic [7:0]  word_address;
    logic [15:0] write_word;
    logic        serial_data_out;
    logic        out_valid;
    logic        out_stall;
    logic        chip_select;
    logic        clock_pulse;
    logic        serial_data_in;
    logic        output_float;
    logic        busy_res;
    logic [15:0] read_word;
    logic        word_valid;
    logic        done_res;
    logic        rejected;
    int          fail_count;
    int          pending;

    int unsigned slots_sent = 0;
    int unsigned idle_cycles = 0;
    int          in_mode = IDLE_NONE;
    int          in_mode_left = 0;
    int          out_mode = IDLE_NONE;
    int          out_mode_left = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    microwire_eeprom_master_top u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_cmd             (cmd),
        .i_word_address    (word_address),
        .i_write_word      (write_word),
        .i_serial_data_out (serial_data_out),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_chip_select     (chip_select),
        .o_clock_pulse     (clock_pulse),
        .o_serial_data_in  (serial_data_in),
        .o_output_float    (output_float),
        .o_busy_res        (busy_res),
        .o_read_word       (read_word),
        .o_word_valid      (word_valid),
        .o_done_res        (done_res),
        .o_rejected        (rejected)
    );

    mw_slot_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_cmd             (cmd),
        .i_word_address    (word_address),
        .i_write_word      (write_word),
        .i_serial_data_out (serial_data_out),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_chip_select     (chip_select),
        .i_clock_pulse     (clock_pulse),
        .i_serial_data_in  (serial_data_in),
        .i_output_float    (output_float),
        .i_busy_res        (busy_res),
        .i_read_word       (read_word),
        .i_word_valid      (word_valid),
        .i_done_res        (done_res),
        .i_rejected        (rejected),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // wait before the next beat, style changes every few dozen beats
    function automatic int unsigned pick_wait(inout int mode, inout int left);
        if (left == 0) begin
            mode = $urandom_range(IDLE_NONE, IDLE_LIGHT);
            left = $urandom_range(10, 80);
        end
        left--;
        case (mode)
            IDLE_FULL:  return $urandom_range(0, 15);
            IDLE_LIGHT: return $urandom_range(0, 3);
            default:    return 0;
        endcase
    endfunction

    // one input beat, called and returning at a falling edge
    task automatic send_slot(input logic [2:0] c, input logic [7:0] a, input logic [15:0] w,
                             input logic d);
        int unsigned gap;
        gap = pick_wait(in_mode, in_mode_left);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        cmd = c;
        word_address = a;
        write_word = w;
        serial_data_out = d;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        slots_sent++;
    endtask

    // hold the sender until every predicted slot has come out
    task automatic drain_results();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // command beat, tick beats for its body, then the write busy wait
    task automatic run_sequence(input logic [2:0] c, input logic [7:0] a, input logic [15:0] w,
                                input int unsigned wait_len, input int skew,
                                input int unsigned noise, input int unsigned dout_sel);
        int         body;
        logic [2:0] bc;
        logic       d;
        case (c) inside
            CMD_READ:         body = 28;
            CMD_WRITE:        body = 27;
            CMD_WEN, CMD_WDS: body = 12;
            default:          body = 0;
        endcase
        body = body + skew;
        if (body < 0) body = 0;
        send_slot(c, a, w, 1'($urandom_range(0, 1)));
        for (int i = 0; i < body; i++) begin
            bc = CMD_TICK;
            if (noise != 0 && $urandom_range(1, noise) == 1) bc = 3'($urandom_range(0, 7));
            if (dout_sel == DOUT_RAND) d = 1'($urandom_range(0, 1));
            else d = (dout_sel == DOUT_HIGH);
            send_slot(bc, 8'($urandom_range(0, 255)), 16'($urandom()), d);
        end
        if (c == CMD_WRITE) begin
            repeat (wait_len) send_slot(CMD_TICK, 8'($urandom_range(0, 255)),
                                        16'($urandom()), 1'b0);
            send_slot(CMD_TICK, 8'($urandom_range(0, 255)), 16'($urandom()), 1'b1);
        end
    endtask

    // output stall per beat
    initial begin
        int unsigned hold;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            hold = pick_wait(out_mode, out_mode_left);
            if (hold != 0) begin
                out_stall = 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // cycles in which neither channel moves a beat
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // stimulus
    initial begin
        int unsigned next_drain;
        int unsigned wait_len;
        int unsigned noise;
        int          skew;
        int unsigned n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_TICK;
        word_address = '0;
        write_word = '0;
        serial_data_out = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // idle ticks, unknown commands while idle
        send_slot(CMD_TICK, 8'hFF, 16'hFFFF, 1'b1);
        for (int u = CMD_WDS + 1; u < 8; u++) send_slot(3'(u), 8'hFF, 16'hFFFF, 1'b1);
        // address and data extremes for every command
        run_sequence(CMD_READ, 8'hFF, 16'h0000, 0, 0, 0, DOUT_HIGH);
        run_sequence(CMD_READ, 8'h00, 16'hFFFF, 0, 0, 0, DOUT_LOW);
        run_sequence(CMD_WRITE, 8'h00, 16'hFFFF, 3, 0, 0, DOUT_RAND);
        run_sequence(CMD_WRITE, 8'hFF, 16'h0000, 0, 0, 0, DOUT_RAND);
        run_sequence(CMD_WEN, 8'h00, 16'h0000, 0, 0, 0, DOUT_RAND);
        run_sequence(CMD_WDS, 8'hFF, 16'hFFFF, 0, 0, 0, DOUT_RAND);
        // commands arriving while a read runs
        run_sequence(CMD_READ, 8'h5A, 16'hA5A5, 0, 0, 2, DOUT_RAND);
        drain_results();

        // random sequences with some noise and misaligned bodies
        slots_sent = 0;
        next_drain = DRAIN_EVERY;
        while (slots_sent < RANDOM_SLOTS) begin
            if (slots_sent >= next_drain) begin
                drain_results();
                next_drain += DRAIN_EVERY;
            end
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 8);
                repeat (n) send_slot(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                                     16'($urandom()), 1'($urandom_range(0, 1)));
            end else begin
                wait_len = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 40)
                                                       : $urandom_range(0, 3);
                skew = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 6)) - 3 : 0;
                noise = ($urandom_range(0, 3) == 0) ? 8 : 0;
                run_sequence(3'($urandom_range(CMD_READ, CMD_WDS)), 8'($urandom_range(0, 255)),
                             16'($urandom()), wait_len, skew, noise, DOUT_RAND);
                n = $urandom_range(0, 2);
                repeat (n) send_slot(CMD_TICK, 8'($urandom_range(0, 255)), 16'($urandom()),
                                     1'($urandom_range(0, 1)));
            end
        end

        drain_results();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mwem_pkg.sv
rtl/mwem_front.sv
rtl/mwem_seq.sv
rtl/microwire_eeprom_master_top.sv
bench/mw_slot_checker.sv
bench/testbench.sv
